### src/aaq_pkg.sv
// ----------------------------------------------------------------------------
// aaq_pkg: shared types and constants of the axis-angle to quaternion core
// Holds the channel structs, the per-cell step structs, the fixed-point
// constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aaq_pkg;

  // Default number of CORDIC rotation cells.
  localparam int unsigned CORDIC_STAGES_DEF = 30;

  // Width of the CORDIC datapath (x, y and angle accumulator).
  localparam int unsigned ZW = 34;

  // Square root chain: one result bit per cell.
  localparam int unsigned SQ_IN_W  = 64;
  localparam int unsigned SQ_REM_W = 34;
  localparam int unsigned SQ_STEPS = 32;

  // Divider chain: one quotient bit per cell.
  localparam int unsigned DIV_Q_W = 31;
  localparam int unsigned DIV_N_W = 62;

  // Fixed-point constants in units of 2^-30.
  localparam logic signed [ZW-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Input request and result payloads.
  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               degenerate_axis;
  } out_res_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [SQ_IN_W-1:0]  x;
    logic [SQ_REM_W-1:0] rem;
    logic [31:0]         root;
  } sqrt_step_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    logic [31:0]        dvsr;
    logic [31:0]        rem;
    logic [DIV_Q_W-1:0] low;
    logic [DIV_Q_W-1:0] quo;
  } div_step_t;

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [ZW-1:0] x;
    logic signed [ZW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_step_t;

  // Truncated atan(2^-i) in units of 2^-30 rad.
  function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
    logic [ZW-1:0] r;
    case (idx)
      0: r = 34'd843314856;
      1: r = 34'd497837829;
      2: r = 34'd263043836;
      3: r = 34'd133525158;
      4: r = 34'd67021686;
      5: r = 34'd33543515;
      6: r = 34'd16775850;
      7: r = 34'd8388437;
      8: r = 34'd4194282;
      9: r = 34'd2097149;
      default: r = (idx > 30) ? '0 : ((34'd1 << (30 - idx)) - 34'd1);
    endcase
    return r;
  endfunction

  // Clamp a value to the range [-1.0, 1.0] in Q2.30.
  function automatic logic [31:0] sat_q30(input logic signed [ZW-1:0] v);
    logic [31:0] r;
    if (v > Q30_ONE) begin
      r = 32'h4000_0000;
    end else if (v < -Q30_ONE) begin
      r = 32'hC000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### src/axis_angle_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// axis_angle_to_quaternion_core: axis-angle to unit quaternion converter
// Fully pipelined: axis length by a square root chain, sine and cosine by a
// CORDIC chain, axis normalization and renormalization by divider chains.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+----------------------------
//   request | start, busy, in_data           | taken when start && !busy
//   result  | out_strobe, out_data           | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// One request is taken every cycle; busy stays low.
// The latency is set by the two 32-cell square root chains, the two
// 31-cell divider chains and the CORDIC chain.
// Reset clears the result strobe pipeline and the threshold register.
// The result side cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module axis_angle_to_quaternion_core #(
  parameter int unsigned CORDIC_STAGES = aaq_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  aaq_pkg::in_req_t  in_data,
  output logic              out_strobe,
  output aaq_pkg::out_res_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  localparam int unsigned ZW      = aaq_pkg::ZW;
  localparam int unsigned SQ_N    = aaq_pkg::SQ_STEPS;
  localparam int unsigned DIV_N   = aaq_pkg::DIV_Q_W;
  localparam int unsigned LATENCY = 138 + CORDIC_STAGES;

  typedef struct packed {
    logic [2:0][31:0] axis;
    logic [ZW-1:0]    zr;
    logic             neg;
  } side_a_t;

  typedef struct packed {
    logic [2:0][31:0] axis;
    logic [31:0]      s;
    logic             deg;
    logic             neg;
  } side_b_t;

  typedef struct packed {
    logic [31:0] c;
    logic [31:0] sn;
    logic [2:0]  sgn;
    logic        deg;
  } side_c_t;

  typedef struct packed {
    logic [3:0][31:0] q;
    logic             deg;
  } side_d_t;

  typedef struct packed {
    logic [3:0] sgn;
    logic       deg;
    logic       nz;
  } side_e_t;

  logic                 fire;
  logic [LATENCY-1:0]   vld_r;
  logic [15:0]          thr_r;

  aaq_pkg::in_req_t     p0_r;
  logic [2:0][62:0]     sq1_r;
  side_a_t              sa1_nxt;
  side_a_t              sa1_r;
  side_a_t              sa2_r;
  side_a_t              sa_q;
  logic [63:0]          sum2_r;

  aaq_pkg::sqrt_step_t  sq1_chain [SQ_N+1];
  side_b_t              sb3_r;
  logic [ZW-1:0]        zr3_r;
  side_b_t              sb_q;
  aaq_pkg::rot_step_t   rot_chain [CORDIC_STAGES+1];

  side_c_t              sc4_nxt;
  side_c_t              sc4_r;
  side_c_t              sc_q;
  aaq_pkg::div_step_t   div1_nxt [3];
  aaq_pkg::div_step_t   div1_chain [3][DIV_N+1];

  logic [2:0][61:0]     prod5_r;
  logic [2:0]           psgn5_r;
  logic [31:0]          c5_r;
  logic                 deg5_r;
  side_d_t              sd6_r;
  logic [3:0][61:0]     sqr7_r;
  side_d_t              sd7_r;
  logic [1:0][62:0]     pair8_r;
  side_d_t              sd8_r;
  logic [63:0]          tot9_r;
  side_d_t              sd9_r;
  side_d_t              sd_q;

  aaq_pkg::sqrt_step_t  sq2_chain [SQ_N+1];
  side_e_t              se10_nxt;
  side_e_t              se10_r;
  side_e_t              se_q;
  aaq_pkg::div_step_t   div2_nxt [4];
  aaq_pkg::div_step_t   div2_chain [4][DIV_N+1];

  aaq_pkg::out_res_t    res_nxt;
  aaq_pkg::out_res_t    res_r;

  assign fire      = start && !busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Control: threshold register and the strobe pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      vld_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      vld_r <= {vld_r[LATENCY-2:0], fire};
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    p0_r <= in_data;
  end

  // Axis squares and the reduced CORDIC angle z = -2*angle.
  always_comb begin
    logic signed [ZW-1:0] ang;
    logic signed [ZW-1:0] z0;
    ang         = {{(ZW-32){p0_r.angle[31]}}, p0_r.angle};
    z0          = -(ang <<< 1);
    sa1_nxt.axis = {p0_r.axis_z, p0_r.axis_y, p0_r.axis_x};
    if (z0 > aaq_pkg::Q30_HALF_PI) begin
      sa1_nxt.zr  = z0 - aaq_pkg::Q30_PI;
      sa1_nxt.neg = 1'b1;
    end else if (z0 < -aaq_pkg::Q30_HALF_PI) begin
      sa1_nxt.zr  = z0 + aaq_pkg::Q30_PI;
      sa1_nxt.neg = 1'b1;
    end else begin
      sa1_nxt.zr  = z0;
      sa1_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] pz;
    px = p0_r.axis_x * p0_r.axis_x;
    py = p0_r.axis_y * p0_r.axis_y;
    pz = p0_r.axis_z * p0_r.axis_z;
    sq1_r <= {pz[62:0], py[62:0], px[62:0]};
    sa1_r <= sa1_nxt;
  end

  // Sum of squares.
  always_ff @(posedge clk) begin
    sum2_r <= {1'b0, sq1_r[0]} + {1'b0, sq1_r[1]} + {1'b0, sq1_r[2]};
    sa2_r  <= sa1_r;
  end

  // Axis length chain.
  assign sq1_chain[0] = '{x: sum2_r, rem: '0, root: '0};

  for (genvar g = 0; g < SQ_N; g++) begin : g_len
    aaq_sqrt_cell u_cell (
      .clk      (clk),
      .step_in  (sq1_chain[g]),
      .step_out (sq1_chain[g+1])
    );
  end

  aaq_delay #(.WIDTH($bits(side_a_t)), .DEPTH(SQ_N)) u_dly_a (
    .clk (clk),
    .d   (sa2_r),
    .q   (sa_q)
  );

  // Short-axis test against the threshold.
  always_ff @(posedge clk) begin
    sb3_r.axis <= sa_q.axis;
    sb3_r.s    <= sq1_chain[SQ_N].root;
    sb3_r.deg  <= (sq1_chain[SQ_N].root <= {16'b0, thr_r});
    sb3_r.neg  <= sa_q.neg;
    zr3_r      <= sa_q.zr;
  end

  // Sine and cosine chain.
  assign rot_chain[0] = '{x: aaq_pkg::CORDIC_GAIN, y: '0, z: zr3_r};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    aaq_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .step_in  (rot_chain[g]),
      .step_out (rot_chain[g+1])
    );
  end

  aaq_delay #(.WIDTH($bits(side_b_t)), .DEPTH(CORDIC_STAGES)) u_dly_b (
    .clk (clk),
    .d   (sb3_r),
    .q   (sb_q)
  );

  // Quadrant fix-up, saturation and setup of the axis divisions.
  always_comb begin
    logic signed [ZW-1:0] xf;
    logic signed [ZW-1:0] yf;
    logic [31:0]          amag;
    logic [61:0]          num;
    xf = sb_q.neg ? -rot_chain[CORDIC_STAGES].x : rot_chain[CORDIC_STAGES].x;
    yf = sb_q.neg ? -rot_chain[CORDIC_STAGES].y : rot_chain[CORDIC_STAGES].y;
    sc4_nxt.c   = aaq_pkg::sat_q30(xf);
    sc4_nxt.sn  = aaq_pkg::sat_q30(yf);
    sc4_nxt.deg = sb_q.deg;
    for (int k = 0; k < 3; k++) begin
      amag = sb_q.axis[k][31] ? (32'd0 - sb_q.axis[k]) : sb_q.axis[k];
      num  = {amag, 30'b0} + {31'b0, sb_q.s[31:1]};
      sc4_nxt.sgn[k]   = sb_q.axis[k][31];
      div1_nxt[k].dvsr = sb_q.s;
      div1_nxt[k].rem  = {1'b0, num[61:31]};
      div1_nxt[k].low  = num[30:0];
      div1_nxt[k].quo  = '0;
    end
  end

  always_ff @(posedge clk) begin
    sc4_r <= sc4_nxt;
    for (int k = 0; k < 3; k++) begin
      div1_chain[k][0] <= div1_nxt[k];
    end
  end

  // Unit axis divider lanes.
  for (genvar l = 0; l < 3; l++) begin : g_ulane
    for (genvar g = 0; g < DIV_N; g++) begin : g_cell
      aaq_div_cell u_cell (
        .clk      (clk),
        .step_in  (div1_chain[l][g]),
        .step_out (div1_chain[l][g+1])
      );
    end
  end

  aaq_delay #(.WIDTH($bits(side_c_t)), .DEPTH(DIV_N)) u_dly_c (
    .clk (clk),
    .d   (sc4_r),
    .q   (sc_q)
  );

  // Unit axis times sine.
  always_ff @(posedge clk) begin
    logic [31:0] snmag;
    snmag = sc_q.sn[31] ? (32'd0 - sc_q.sn) : sc_q.sn;
    for (int k = 0; k < 3; k++) begin
      prod5_r[k] <= div1_chain[k][DIV_N].quo * snmag[30:0];
      psgn5_r[k] <= sc_q.sgn[k] ^ sc_q.sn[31];
    end
    c5_r   <= sc_q.c;
    deg5_r <= sc_q.deg;
  end

  // Round the products and apply signs.
  always_ff @(posedge clk) begin
    logic [61:0] rnd;
    for (int k = 0; k < 3; k++) begin
      rnd = prod5_r[k] + 62'd536870912;
      sd6_r.q[k+1] <= psgn5_r[k] ? (32'd0 - {1'b0, rnd[60:30]}) : {1'b0, rnd[60:30]};
    end
    sd6_r.q[0] <= c5_r;
    sd6_r.deg  <= deg5_r;
  end

  // Squares of the four parts.
  always_ff @(posedge clk) begin
    logic [31:0] qm;
    for (int k = 0; k < 4; k++) begin
      qm = sd6_r.q[k][31] ? (32'd0 - sd6_r.q[k]) : sd6_r.q[k];
      sqr7_r[k] <= qm[30:0] * qm[30:0];
    end
    sd7_r <= sd6_r;
  end

  // Norm squared as a two-level adder tree.
  always_ff @(posedge clk) begin
    pair8_r[0] <= {1'b0, sqr7_r[0]} + {1'b0, sqr7_r[1]};
    pair8_r[1] <= {1'b0, sqr7_r[2]} + {1'b0, sqr7_r[3]};
    sd8_r      <= sd7_r;
    tot9_r     <= {1'b0, pair8_r[0]} + {1'b0, pair8_r[1]};
    sd9_r      <= sd8_r;
  end

  // Norm chain.
  assign sq2_chain[0] = '{x: tot9_r, rem: '0, root: '0};

  for (genvar g = 0; g < SQ_N; g++) begin : g_norm
    aaq_sqrt_cell u_cell (
      .clk      (clk),
      .step_in  (sq2_chain[g]),
      .step_out (sq2_chain[g+1])
    );
  end

  aaq_delay #(.WIDTH($bits(side_d_t)), .DEPTH(SQ_N)) u_dly_d (
    .clk (clk),
    .d   (sd9_r),
    .q   (sd_q)
  );

  // Setup of the renormalizing divisions.
  always_comb begin
    logic [31:0] n;
    logic [31:0] qm;
    logic [61:0] num;
    n            = sq2_chain[SQ_N].root;
    se10_nxt.deg = sd_q.deg;
    se10_nxt.nz  = (n == 32'd0);
    for (int k = 0; k < 4; k++) begin
      qm  = sd_q.q[k][31] ? (32'd0 - sd_q.q[k]) : sd_q.q[k];
      num = {1'b0, qm[30:0], 30'b0} + {31'b0, n[31:1]};
      se10_nxt.sgn[k]  = sd_q.q[k][31];
      div2_nxt[k].dvsr = n;
      div2_nxt[k].rem  = {1'b0, num[61:31]};
      div2_nxt[k].low  = num[30:0];
      div2_nxt[k].quo  = '0;
    end
  end

  always_ff @(posedge clk) begin
    se10_r <= se10_nxt;
    for (int k = 0; k < 4; k++) begin
      div2_chain[k][0] <= div2_nxt[k];
    end
  end

  // Renormalizing divider lanes.
  for (genvar l = 0; l < 4; l++) begin : g_nlane
    for (genvar g = 0; g < DIV_N; g++) begin : g_cell
      aaq_div_cell u_cell (
        .clk      (clk),
        .step_in  (div2_chain[l][g]),
        .step_out (div2_chain[l][g+1])
      );
    end
  end

  aaq_delay #(.WIDTH($bits(side_e_t)), .DEPTH(DIV_N)) u_dly_e (
    .clk (clk),
    .d   (se10_r),
    .q   (se_q)
  );

  // Result selection: identity for a short axis or a zero norm.
  always_comb begin
    logic [3:0][31:0] part;
    logic [30:0]      qs;
    for (int k = 0; k < 4; k++) begin
      qs = (div2_chain[k][DIV_N].quo > 31'd1073741824) ? 31'd1073741824
                                                        : div2_chain[k][DIV_N].quo;
      part[k] = se_q.sgn[k] ? (32'd0 - {1'b0, qs}) : {1'b0, qs};
    end
    if (se_q.deg || se_q.nz) begin
      res_nxt.quat_w = 32'sd1073741824;
      res_nxt.quat_x = '0;
      res_nxt.quat_y = '0;
      res_nxt.quat_z = '0;
    end else begin
      res_nxt.quat_w = part[0];
      res_nxt.quat_x = part[1];
      res_nxt.quat_y = part[2];
      res_nxt.quat_z = part[3];
    end
    res_nxt.degenerate_axis = se_q.deg;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_data   = res_r;
  assign out_strobe = vld_r[LATENCY-1];

endmodule

### src/aaq_delay.sv
// ----------------------------------------------------------------------------
// aaq_delay: shift line for side data
// Carries data that rides beside a cell chain, with one register per chain cell.
// ----------------------------------------------------------------------------
module aaq_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // Each tap takes the value of the one before it.
  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

### src/aaq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aaq_sqrt_cell: one step of a digit-by-digit integer square root
// Consumes two radicand bits and produces one root bit per cycle.
// ----------------------------------------------------------------------------
module aaq_sqrt_cell (
  input  logic                    clk,
  input  aaq_pkg::sqrt_step_t     step_in,
  output aaq_pkg::sqrt_step_t     step_out
);

  logic [35:0]         rem_sh;
  logic [35:0]         trial;
  logic [35:0]         diff;
  aaq_pkg::sqrt_step_t step_nxt;
  aaq_pkg::sqrt_step_t step_r;

  // Bring down two bits and try to subtract 4*root + 1.
  always_comb begin
    rem_sh     = {step_in.rem, step_in.x[aaq_pkg::SQ_IN_W-1 -: 2]};
    trial      = {2'b00, step_in.root, 2'b01};
    diff       = rem_sh - trial;
    step_nxt.x = {step_in.x[aaq_pkg::SQ_IN_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      step_nxt.rem  = diff[aaq_pkg::SQ_REM_W-1:0];
      step_nxt.root = {step_in.root[30:0], 1'b1};
    end else begin
      step_nxt.rem  = rem_sh[aaq_pkg::SQ_REM_W-1:0];
      step_nxt.root = {step_in.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

  assign step_out = step_r;

endmodule

### src/aaq_div_cell.sv
// ----------------------------------------------------------------------------
// aaq_div_cell: one step of a restoring divider
// Produces one quotient bit per cycle and passes the divisor along.
// ----------------------------------------------------------------------------
module aaq_div_cell (
  input  logic               clk,
  input  aaq_pkg::div_step_t step_in,
  output aaq_pkg::div_step_t step_out
);

  logic [32:0]        rem_sh;
  logic [32:0]        dvsr_ext;
  logic [32:0]        diff;
  aaq_pkg::div_step_t step_nxt;
  aaq_pkg::div_step_t step_r;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    rem_sh         = {step_in.rem, step_in.low[aaq_pkg::DIV_Q_W-1]};
    dvsr_ext       = {1'b0, step_in.dvsr};
    diff           = rem_sh - dvsr_ext;
    step_nxt.dvsr  = step_in.dvsr;
    step_nxt.low   = {step_in.low[aaq_pkg::DIV_Q_W-2:0], 1'b0};
    if (rem_sh >= dvsr_ext) begin
      step_nxt.rem = diff[31:0];
      step_nxt.quo = {step_in.quo[aaq_pkg::DIV_Q_W-2:0], 1'b1};
    end else begin
      step_nxt.rem = rem_sh[31:0];
      step_nxt.quo = {step_in.quo[aaq_pkg::DIV_Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

  assign step_out = step_r;

endmodule

### src/aaq_cordic_cell.sv
// ----------------------------------------------------------------------------
// aaq_cordic_cell: one rotation-mode CORDIC micro-rotation
// Turns the vector by +/- atan(2^-STAGE) toward a zero angle residue.
// ----------------------------------------------------------------------------
module aaq_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic               clk,
  input  aaq_pkg::rot_step_t step_in,
  output aaq_pkg::rot_step_t step_out
);

  localparam logic signed [aaq_pkg::ZW-1:0] ATAN = aaq_pkg::atan_entry(STAGE);

  logic signed [aaq_pkg::ZW-1:0] dx;
  logic signed [aaq_pkg::ZW-1:0] dy;
  aaq_pkg::rot_step_t            step_nxt;
  aaq_pkg::rot_step_t            step_r;

  // Rotate in the direction that drives the residue angle toward zero.
  always_comb begin
    dx = step_in.y >>> STAGE;
    dy = step_in.x >>> STAGE;
    if (!step_in.z[aaq_pkg::ZW-1]) begin
      step_nxt.x = step_in.x - dx;
      step_nxt.y = step_in.y + dy;
      step_nxt.z = step_in.z - ATAN;
    end else begin
      step_nxt.x = step_in.x + dx;
      step_nxt.y = step_in.y - dy;
      step_nxt.z = step_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
  end

  assign step_out = step_r;

endmodule

### src/aaq_checker.sv
// ----------------------------------------------------------------------------
// aaq_checker: port-level checks of the quaternion core
// Watches the result port for unit-range values, the identity on a short
// axis, and a quiet result port after reset.
// ----------------------------------------------------------------------------
module aaq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_strobe,
  input aaq_pkg::out_res_t out_data
);

  // A short axis always yields the identity quaternion.
  a_deg_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.degenerate_axis |->
      out_data.quat_w == 32'sd1073741824 && out_data.quat_x == 32'sd0 &&
      out_data.quat_y == 32'sd0 && out_data.quat_z == 32'sd0)
    else $error("short axis result is not the identity");

  // Every part of a result lies in [-1.0, 1.0].
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      $signed(out_data.quat_w) <= 32'sd1073741824 &&
      $signed(out_data.quat_w) >= -32'sd1073741824 &&
      $signed(out_data.quat_x) <= 32'sd1073741824 &&
      $signed(out_data.quat_x) >= -32'sd1073741824 &&
      $signed(out_data.quat_y) <= 32'sd1073741824 &&
      $signed(out_data.quat_y) >= -32'sd1073741824 &&
      $signed(out_data.quat_z) <= 32'sd1073741824 &&
      $signed(out_data.quat_z) >= -32'sd1073741824)
    else $error("result part out of unit range");

  // No result appears in the cycle after a reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

endmodule

bind axis_angle_to_quaternion_core aaq_checker u_aaq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
